@@ design/assert_macros.svh @@
// Assertion macros shared by the lit-span rasterizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mlsr_pkg.sv @@
// Types and constants shared by the lit-span rasterizer modules.
package mlsr_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_RADIUS   = 3'd2,
    CFG_ILLUM    = 3'd3,
    CFG_WAXING   = 3'd4
  } cfg_idx_e;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam int unsigned RAD_W     = 18;
  localparam int unsigned ROOT_W    = 9;
  localparam int unsigned ISQ_STEPS = 9;
  localparam int unsigned ISQ_CNT_W = 4;

  typedef logic [RAD_W-1:0]  rad_t;
  typedef logic [ROOT_W-1:0] root_t;

  localparam int unsigned QUO_W = 17;
  localparam int unsigned KR_W  = 23;
  localparam int unsigned ACC_W = 31;

  localparam logic [16:0] ILLUM_ONE = 17'd65536;
  localparam logic [17:0] K_ONE     = 18'd65536;

endpackage

@@ design/mlsr_isqrt.sv @@
// Integer square root, one two-bit digit of the radicand per cycle.
module mlsr_isqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  mlsr_pkg::rad_t radicand_i,
  output logic           busy_o,
  output mlsr_pkg::root_t root_o
);
  import mlsr_pkg::*;

  logic [ISQ_CNT_W-1:0] cnt_q;
  rad_t                 n_q;
  logic [ROOT_W:0]      rem_q;
  root_t                root_q;
  logic [ROOT_W+2:0]    rem_sh;
  logic [ROOT_W+2:0]    rem_next;
  logic [ROOT_W+1:0]    trial;
  logic                 take;

  always_comb begin
    rem_sh   = {rem_q, n_q[RAD_W-1 -: 2]};
    trial    = {root_q, 2'b01};
    take     = rem_sh >= {1'b0, trial};
    rem_next = take ? (rem_sh - {1'b0, trial}) : rem_sh;
  end

  assign busy_o = (cnt_q != '0);
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= ISQ_CNT_W'(ISQ_STEPS);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_o) begin
      n_q    <= {n_q[RAD_W-3:0], 2'b00};
      rem_q  <= rem_next[ROOT_W:0];
      root_q <= {root_q[ROOT_W-2:0], take};
    end
  end

endmodule

@@ design/moon_lit_span_raster_top.sv @@
// Top level of the moon lit-span rasterizer: config registers, sequencer and datapath.
//
// The block takes one signed row offset per word on the s_axis channel and returns
// the lit horizontal span of that row of a moon disc on the m_axis channel.
// Center, radius, illumination and waxing are set through the write port (cfg_we_i,
// cfg_index_i, cfg_wdata_i), by the user while the block is idle; it is not enforced.
// A row outside the disc is dropped in the cycle it is accepted.
// Any other row runs through a bit-serial divider (the edge root and the
// k*r product run beside it), a 9-digit square root and a 9-bit serial multiply.
// A new row is accepted only after the previous row has left the sequencer;
// rows whose span is empty give no word.
// The result sits in an output register, so the next row is taken while it waits.
// When the receiver stalls, a finished row waits until the register is free.
// Reset clears the sequencer and the output valid and loads the register defaults.
module moon_lit_span_raster_top #(
  parameter int unsigned MAX_RADIUS = 127
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mlsr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mlsr_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // Fields from bit 0: row_offset[7:0].
  input  logic [mlsr_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // Fields from bit 0: span_left[12:0], span_row[25:13], span_width[33:26], zeros.
  output logic [mlsr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);
  import mlsr_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned R_LIMIT = (MAX_RADIUS > 127) ? 127 : MAX_RADIUS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SQ0,
    S_SQRT,
    S_MUL,
    S_FIN
  } state_e;

  state_e            state_q;
  logic [4:0]        cnt_q;
  logic              out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic signed [11:0] center_x_q;
  logic signed [11:0] center_y_q;
  logic [6:0]         radius_q;
  logic [16:0]        illum_q;
  logic               waxing_q;

  logic signed [7:0] dy_q;
  logic [6:0]        r_q;
  logic [13:0]       rsq_q;
  logic [13:0]       drem_q;
  logic [QUO_W-1:0]  dbits_q;
  logic [QUO_W-1:0]  quo_q;
  logic [16:0]       kmag_q;
  logic              kneg_q;
  logic [6:0]        rsh_q;
  logic [KR_W-1:0]   kr_q;
  root_t             sqsh_q;
  logic [ACC_W-1:0]  acc_q;

  logic              in_acc;
  logic signed [7:0] dy_in;
  logic [7:0]        ady;
  logic [6:0]        r_eff;
  logic              out_of_disc;
  logic [13:0]       rsq_in;
  logic [15:0]       dsq_in;
  logic [13:0]       s_in;
  logic [16:0]       illum_sat;
  logic [17:0]       twice;
  logic              kneg_in;
  logic [17:0]       kmag_in;

  logic [14:0]       div_t;
  logic              div_take;
  logic [13:0]       div_diff;
  logic              div_last;

  logic              edge_busy;
  root_t             edge_root;
  logic              sq_start;
  logic              sq_busy;
  root_t             sq_root;

  logic signed [13:0] cx14;
  logic signed [13:0] term14;
  logic signed [13:0] edge14;
  logic signed [13:0] left14;
  logic signed [13:0] right14;
  logic signed [13:0] width14;
  logic signed [12:0] row13;
  logic               span_empty;
  logic               out_free;
  logic               out_load;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign out_load        = (state_q == S_FIN) && !span_empty && out_free;
  assign sq_start        = (state_q == S_SQ0);
  assign div_last        = (state_q == S_DIV) && (cnt_q == '0);

  always_comb begin
    dy_in       = signed'(s_axis_tdata_i[7:0]);
    ady         = dy_in[7] ? 8'(-dy_in) : 8'(dy_in);
    r_eff       = (radius_q > 7'(R_LIMIT)) ? 7'(R_LIMIT) : radius_q;
    out_of_disc = ady > {1'b0, r_eff};
    rsq_in      = {7'b0, r_eff} * {7'b0, r_eff};
    dsq_in      = {8'b0, ady} * {8'b0, ady};
    s_in        = rsq_in - dsq_in[13:0];
    illum_sat   = (illum_q > ILLUM_ONE) ? ILLUM_ONE : illum_q;
    twice       = {illum_sat, 1'b0};
    kneg_in     = twice > K_ONE;
    kmag_in     = kneg_in ? (twice - K_ONE) : (K_ONE - twice);
  end

  always_comb begin
    div_t    = {drem_q, dbits_q[QUO_W-1]};
    div_take = div_t >= {1'b0, rsq_q};
    div_diff = div_take ? 14'(div_t - {1'b0, rsq_q}) : div_t[13:0];
  end

  always_comb begin
    cx14   = {{2{center_x_q[11]}}, center_x_q};
    edge14 = {7'b0, edge_root[6:0]};
    if (r_q == '0) begin
      term14 = '0;
    end else if (kneg_q) begin
      term14 = -signed'({7'b0, acc_q[ACC_W-1 -: 7]});
    end else begin
      term14 = signed'({7'b0, acc_q[ACC_W-1 -: 7]});
    end
    if (waxing_q) begin
      left14  = cx14 + term14;
      right14 = cx14 + edge14;
    end else begin
      left14  = cx14 - edge14;
      right14 = cx14 + term14;
    end
    span_empty = left14 > right14;
    width14    = right14 - left14 + 14'sd1;
    row13      = {center_y_q[11], center_y_q} + {{5{dy_q[7]}}, dy_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      radius_q   <= '0;
      illum_q    <= '0;
      waxing_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CENTER_X: center_x_q <= signed'(cfg_wdata_i[11:0]);
        CFG_CENTER_Y: center_y_q <= signed'(cfg_wdata_i[11:0]);
        CFG_RADIUS:   radius_q   <= cfg_wdata_i[6:0];
        CFG_ILLUM:    illum_q    <= cfg_wdata_i[16:0];
        CFG_WAXING:   waxing_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {6'b0, width14[7:0], row13, left14[12:0]};
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && !out_of_disc) begin
            state_q <= S_DIV;
            cnt_q   <= 5'(QUO_W - 1);
          end
        end
        S_DIV: begin
          if (cnt_q == '0) begin
            state_q <= S_SQ0;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_SQ0: begin
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (!sq_busy) begin
            state_q <= S_MUL;
            cnt_q   <= 5'(ROOT_W - 1);
          end
        end
        S_MUL: begin
          if (cnt_q == '0) begin
            state_q <= S_FIN;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_FIN: begin
          if (span_empty) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dy_q    <= dy_in;
      r_q     <= r_eff;
      rsq_q   <= rsq_in;
      drem_q  <= {1'b0, s_in[13:1]};
      dbits_q <= {s_in[0], 16'b0};
      quo_q   <= '0;
      kmag_q  <= kmag_in[16:0];
      kneg_q  <= kneg_in;
      rsh_q   <= r_eff;
      kr_q    <= '0;
    end else if (state_q == S_DIV) begin
      drem_q  <= div_diff;
      dbits_q <= {dbits_q[QUO_W-2:0], 1'b0};
      quo_q   <= {quo_q[QUO_W-2:0], div_take};
      if (cnt_q >= 5'(QUO_W - 7)) begin
        kr_q  <= {kr_q[KR_W-2:0], 1'b0} + (rsh_q[6] ? {6'b0, kmag_q} : '0);
        rsh_q <= {rsh_q[5:0], 1'b0};
      end
    end
    if (state_q == S_SQRT && !sq_busy) begin
      sqsh_q <= sq_root;
      acc_q  <= '0;
    end else if (state_q == S_MUL) begin
      acc_q  <= {acc_q[ACC_W-2:0], 1'b0} + (sqsh_q[ROOT_W-1] ? {8'b0, kr_q} : '0);
      sqsh_q <= {sqsh_q[ROOT_W-2:0], 1'b0};
    end
  end

  mlsr_isqrt u_edge_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .radicand_i ({4'b0, s_in}),
    .busy_o     (edge_busy),
    .root_o     (edge_root)
  );

  mlsr_isqrt u_sq_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i ({1'b0, quo_q}),
    .busy_o     (sq_busy),
    .root_o     (sq_root)
  );

  `ASSERT_IMPLIES(a_edge_done, clk_i, rst_ni, div_last, !edge_busy, "edge root late")
  `ASSERT_IMPLIES(a_sq_in_sqrt, clk_i, rst_ni, sq_busy, state_q == S_SQRT, "stray root busy")
  `ASSERT_NEXT(a_oob_drop, clk_i, rst_ni, in_acc && out_of_disc, state_q == S_IDLE, "row kept")

endmodule
